// ===== rtl/core/polyline_segment_crossing_test_defines.svh =====
// ---------------------------------------------------------------------------
// Polyline segment crossing test - assertion macros
// Shared concurrent assertion helpers for the crossing test RTL.
// ---------------------------------------------------------------------------
`ifndef POLYLINE_SEGMENT_CROSSING_TEST_DEFINES_SVH
`define POLYLINE_SEGMENT_CROSSING_TEST_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PSCT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define PSCT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/psct_pkg.sv =====
// ---------------------------------------------------------------------------
// psct_pkg
// Types and constants shared by the polyline segment crossing test.
// ---------------------------------------------------------------------------
`default_nettype none

package psct_pkg;

   // Coordinate width default
   localparam int COORD_WIDTH_DEFAULT = 16;

   // Register port geometry
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 4;

   // Number of cross products per segment pair
   localparam int CROSS_COUNT = 4;
   localparam int CROSS_IDX_WIDTH = $clog2(CROSS_COUNT);

   // Register indexes
   typedef enum logic [1:0] {
      REG_SEG_START_X = 2'd0,
      REG_SEG_START_Y = 2'd1,
      REG_SEG_END_X   = 2'd2,
      REG_SEG_END_Y   = 2'd3
   } reg_index_type;

   // Cross product selectors
   localparam logic [CROSS_IDX_WIDTH-1:0] CROSS_VS_UE_US = 2'd0;
   localparam logic [CROSS_IDX_WIDTH-1:0] CROSS_UE_VE_US = 2'd1;
   localparam logic [CROSS_IDX_WIDTH-1:0] CROSS_US_VE_VS = 2'd2;
   localparam logic [CROSS_IDX_WIDTH-1:0] CROSS_VE_UE_VS = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic                       load;    // capture accepted point
      logic                       issue;   // start one cross product
      logic [CROSS_IDX_WIDTH-1:0] idx;     // which cross product
      logic                       commit;  // fold hit into state
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last;                          // captured point ends the query
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/psct_ctrl.sv =====
// ---------------------------------------------------------------------------
// psct_ctrl
// Sequencer: accepts a point, steps the four cross products through the
// shared multiplier pair, commits the hit and ends a query with a result beat.
// ---------------------------------------------------------------------------
`default_nettype none

`include "polyline_segment_crossing_test_defines.svh"

module psct_ctrl
   import psct_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   input  status_type status,
   output cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CROSS,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   state_type                  state_ff, state_in;
   logic [CROSS_IDX_WIDTH-1:0] cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       accept;
   logic                       hold;
   logic                       emit;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   // final point waits while the previous result beat is still pending
   assign hold = (state_ff == ST_DECIDE) && status.last && rsp_valid_ff && rsp_stall;
   assign emit = (state_ff == ST_DECIDE) && !hold && status.last;

   // command decode
   always_comb begin
      cmd.load   = accept;
      cmd.issue  = (state_ff == ST_CROSS);
      cmd.idx    = cnt_ff;
      cmd.commit = (state_ff == ST_DECIDE) && !hold;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CROSS;
               cnt_in   = '0;
            end
         end
         ST_CROSS: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CROSS_IDX_WIDTH'(CROSS_COUNT - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!hold) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output beat register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   `PSCT_ASSERT_NXT(a_accept_starts_cross, clock, reset, accept, state_ff == ST_CROSS, "accepted point did not start the cross sequence")
   `PSCT_ASSERT_NXT(a_pending_blocks_emit, clock, reset, hold, state_ff == ST_DECIDE && rsp_valid_ff, "final point left decide while result beat pending")
   `PSCT_ASSERT_IMP(a_rsp_from_decide, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_DECIDE), "result beat raised outside decide")

endmodule

`default_nettype wire

// ===== rtl/core/psct_datapath.sv =====
// ---------------------------------------------------------------------------
// psct_datapath
// Query segment registers, curve point state, bounding-box test and a
// shared pair of multipliers that evaluates one cross product sign per step.
// ---------------------------------------------------------------------------
`default_nettype none

module psct_datapath
   import psct_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
)(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  cmd_type                            cmd,
   output status_type                         status,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_y,
   input  wire logic                          req_starts_curve,
   input  wire logic                          req_ends_query,
   output logic                               rsp_crossed,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]          csr_prdata
);

   localparam int DW = COORD_WIDTH + 1;   // coordinate difference
   localparam int PW = 2 * DW;            // product
   localparam int EXT = CSR_DATA_WIDTH - COORD_WIDTH;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   // query segment registers
   coord_type     seg_start_x_ff, seg_start_y_ff, seg_end_x_ff, seg_end_y_ff;
   coord_type     seg_start_x_in, seg_start_y_in, seg_end_x_in, seg_end_y_in;
   logic          csr_wr;
   reg_index_type csr_idx;

   // curve state and captured point
   coord_type prev_x_ff, prev_y_ff, prev_x_in, prev_y_in;
   coord_type cur_x_ff, cur_y_ff, cur_x_in, cur_y_in;
   logic      have_prev_ff, have_prev_in;
   logic      hit_seen_ff, hit_seen_in;
   logic      test_ff, test_in;
   logic      last_ff, last_in;
   logic      crossed_ff, crossed_in;

   // box test
   coord_type umax_x, umin_x, umax_y, umin_y;
   coord_type vmax_x, vmin_x, vmax_y, vmin_y;
   logic      box_ok_ff;

   // cross product pipe
   coord_type                  ma, sa, mb, sb, mc, sc, md, sd;
   logic signed [DW-1:0]       op_a, op_b, op_c, op_d;
   logic signed [PW-1:0]       prod_p_ff, prod_q_ff;
   logic                       pvalid_ff;
   logic [CROSS_IDX_WIDTH-1:0] pidx_ff;
   logic signed [PW:0]         diff;
   logic [CROSS_COUNT-1:0]     neg_ff, zero_ff, pos;

   logic rej_u, rej_v, hit, hit_new;

   // register port
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);

   always_comb begin
      seg_start_x_in = seg_start_x_ff;
      seg_start_y_in = seg_start_y_ff;
      seg_end_x_in   = seg_end_x_ff;
      seg_end_y_in   = seg_end_y_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_SEG_START_X: seg_start_x_in = csr_pwdata[COORD_WIDTH-1:0];
            REG_SEG_START_Y: seg_start_y_in = csr_pwdata[COORD_WIDTH-1:0];
            REG_SEG_END_X:   seg_end_x_in   = csr_pwdata[COORD_WIDTH-1:0];
            REG_SEG_END_Y:   seg_end_y_in   = csr_pwdata[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_SEG_START_X: csr_prdata = {{EXT{seg_start_x_ff[COORD_WIDTH-1]}}, seg_start_x_ff};
         REG_SEG_START_Y: csr_prdata = {{EXT{seg_start_y_ff[COORD_WIDTH-1]}}, seg_start_y_ff};
         REG_SEG_END_X:   csr_prdata = {{EXT{seg_end_x_ff[COORD_WIDTH-1]}}, seg_end_x_ff};
         REG_SEG_END_Y:   csr_prdata = {{EXT{seg_end_y_ff[COORD_WIDTH-1]}}, seg_end_y_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // bounding boxes of curve segment (prev -> cur) and query segment
   always_comb begin
      umax_x = (prev_x_ff > cur_x_ff) ? prev_x_ff : cur_x_ff;
      umin_x = (prev_x_ff < cur_x_ff) ? prev_x_ff : cur_x_ff;
      umax_y = (prev_y_ff > cur_y_ff) ? prev_y_ff : cur_y_ff;
      umin_y = (prev_y_ff < cur_y_ff) ? prev_y_ff : cur_y_ff;
      vmax_x = (seg_start_x_ff > seg_end_x_ff) ? seg_start_x_ff : seg_end_x_ff;
      vmin_x = (seg_start_x_ff < seg_end_x_ff) ? seg_start_x_ff : seg_end_x_ff;
      vmax_y = (seg_start_y_ff > seg_end_y_ff) ? seg_start_y_ff : seg_end_y_ff;
      vmin_y = (seg_start_y_ff < seg_end_y_ff) ? seg_start_y_ff : seg_end_y_ff;
   end

   // operand select: cross product is (ma-sa)*(mb-sb) - (mc-sc)*(md-sd)
   always_comb begin
      case (cmd.idx)
         CROSS_VS_UE_US: begin
            ma = seg_start_x_ff; sa = prev_x_ff;
            mb = cur_y_ff;       sb = prev_y_ff;
            mc = cur_x_ff;       sc = prev_x_ff;
            md = seg_start_y_ff; sd = prev_y_ff;
         end
         CROSS_UE_VE_US: begin
            ma = cur_x_ff;       sa = prev_x_ff;
            mb = seg_end_y_ff;   sb = prev_y_ff;
            mc = seg_end_x_ff;   sc = prev_x_ff;
            md = cur_y_ff;       sd = prev_y_ff;
         end
         CROSS_US_VE_VS: begin
            ma = prev_x_ff;      sa = seg_start_x_ff;
            mb = seg_end_y_ff;   sb = seg_start_y_ff;
            mc = seg_end_x_ff;   sc = seg_start_x_ff;
            md = prev_y_ff;      sd = seg_start_y_ff;
         end
         CROSS_VE_UE_VS: begin
            ma = seg_end_x_ff;   sa = seg_start_x_ff;
            mb = cur_y_ff;       sb = seg_start_y_ff;
            mc = cur_x_ff;       sc = seg_start_x_ff;
            md = seg_end_y_ff;   sd = seg_start_y_ff;
         end
         default: begin
            ma = '0; sa = '0; mb = '0; sb = '0;
            mc = '0; sc = '0; md = '0; sd = '0;
         end
      endcase
   end

   // exact differences, one bit wider than a coordinate
   assign op_a = {ma[COORD_WIDTH-1], ma} - {sa[COORD_WIDTH-1], sa};
   assign op_b = {mb[COORD_WIDTH-1], mb} - {sb[COORD_WIDTH-1], sb};
   assign op_c = {mc[COORD_WIDTH-1], mc} - {sc[COORD_WIDTH-1], sc};
   assign op_d = {md[COORD_WIDTH-1], md} - {sd[COORD_WIDTH-1], sd};

   // sign of the registered product difference
   assign diff = {prod_p_ff[PW-1], prod_p_ff} - {prod_q_ff[PW-1], prod_q_ff};

   // straddle test: reject when a pair of signs is strictly opposite
   assign pos     = ~neg_ff & ~zero_ff;
   assign rej_u   = (neg_ff[CROSS_VS_UE_US] && pos[CROSS_UE_VE_US])
                 || (pos[CROSS_VS_UE_US] && neg_ff[CROSS_UE_VE_US]);
   assign rej_v   = (neg_ff[CROSS_US_VE_VS] && pos[CROSS_VE_UE_VS])
                 || (pos[CROSS_US_VE_VS] && neg_ff[CROSS_VE_UE_VS]);
   assign hit     = test_ff && box_ok_ff && !rej_u && !rej_v;
   assign hit_new = hit_seen_ff || hit;

   // point capture and commit
   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      test_in      = test_ff;
      last_in      = last_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      have_prev_in = have_prev_ff;
      hit_seen_in  = hit_seen_ff;
      crossed_in   = crossed_ff;
      if (cmd.load) begin
         cur_x_in = req_point_x;
         cur_y_in = req_point_y;
         test_in  = !req_starts_curve && have_prev_ff;
         last_in  = req_ends_query;
      end
      if (cmd.commit) begin
         if (last_ff) begin
            prev_x_in    = '0;
            prev_y_in    = '0;
            have_prev_in = 1'b0;
            hit_seen_in  = 1'b0;
            crossed_in   = hit_new;
         end else begin
            prev_x_in    = cur_x_ff;
            prev_y_in    = cur_y_ff;
            have_prev_in = 1'b1;
            hit_seen_in  = hit_new;
         end
      end
   end

   // control and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_start_x_ff <= '0;
         seg_start_y_ff <= '0;
         seg_end_x_ff   <= '0;
         seg_end_y_ff   <= '0;
         have_prev_ff   <= 1'b0;
         hit_seen_ff    <= 1'b0;
         pvalid_ff      <= 1'b0;
      end else begin
         seg_start_x_ff <= seg_start_x_in;
         seg_start_y_ff <= seg_start_y_in;
         seg_end_x_ff   <= seg_end_x_in;
         seg_end_y_ff   <= seg_end_y_in;
         have_prev_ff   <= have_prev_in;
         hit_seen_ff    <= hit_seen_in;
         pvalid_ff      <= cmd.issue;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_x_ff   <= cur_x_in;
      cur_y_ff   <= cur_y_in;
      test_ff    <= test_in;
      last_ff    <= last_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
      crossed_ff <= crossed_in;
      box_ok_ff  <= !((umax_x < vmin_x) || (vmax_x < umin_x)
                   || (umax_y < vmin_y) || (vmax_y < umin_y));
      prod_p_ff  <= op_a * op_b;
      prod_q_ff  <= op_c * op_d;
      pidx_ff    <= cmd.idx;
      if (pvalid_ff) begin
         neg_ff[pidx_ff]  <= diff[PW];
         zero_ff[pidx_ff] <= (diff == '0);
      end
   end

   assign status.last = last_ff;
   assign rsp_crossed = crossed_ff;

endmodule

`default_nettype wire

// ===== rtl/core/polyline_segment_crossing_test.sv =====
// A new point is accepted only in idle, once the previous point is done; the
// four cross products share one pair of multipliers, one product pair per
// cycle, then a drain and a commit.
// A final point waits in commit while the previous result beat is pending.
// Reset (synchronous): clears the sequencer, the result beat, the curve
// state and sets all four query segment registers to zero.
// ---------------------------------------------------------------------------
// polyline_segment_crossing_test
// Tests streamed curve segments against a query segment held in registers
// and reports one sticky crossed flag per query.
// ---------------------------------------------------------------------------
`default_nettype none

module polyline_segment_crossing_test
   import psct_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
)(
   input  wire logic                          clock,
   input  wire logic                          reset,
   // point channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_point_y,
   input  wire logic                          req_starts_curve,
   input  wire logic                          req_ends_query,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_crossed,
   // register port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]          csr_prdata,
   output logic                               csr_pready
);

   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;

   // sequencer
   psct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // geometry datapath
   psct_datapath #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_starts_curve (req_starts_curve),
      .req_ends_query   (req_ends_query),
      .rsp_crossed      (rsp_crossed),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata)
   );

endmodule

`default_nettype wire
